// ===== hw/rtl/bspline_knot_insertion_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Knot insertion unit assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_KNOT_INSERTION_UNIT_DEFINES_SVH
`define BSPLINE_KNOT_INSERTION_UNIT_DEFINES_SVH

// same-cycle implication
`define BKI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BKI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bki_pkg.sv =====
// ----------------------------------------------------------------------------
// Knot insertion package
// Request and status codes, sequencer states and fixed-point widths.
// ----------------------------------------------------------------------------
package bki_pkg;

    localparam int QW    = 32;   // Q16.16 word
    localparam int DVW   = 50;   // divider remainder width
    localparam int PRW   = 51;   // blend product width
    localparam int ALW   = 17;   // alpha, 0..1.0 in Q16.16
    localparam logic [ALW-1:0] ALPHA_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_KNOT   = 2'd1,
        REQ_POINT  = 2'd2,
        REQ_INSERT = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_ZERO_D = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_ERR,
        S_RNG_A, S_RNG_B, S_RNG_C,
        S_SCAN,
        S_DEN_A, S_DEN_B, S_DEN_C,
        S_SH_RD, S_SH_WR,
        S_BL_K0, S_BL_K1, S_BL_SET, S_BL_DIV, S_BL_MX, S_BL_MY, S_BL_WR,
        S_KS_RD, S_KS_WR,
        S_EM_RD, S_EM_LD
    } t_state;

endpackage

// ===== hw/rtl/bspline_knot_insertion_unit.sv =====
// ----------------------------------------------------------------------------
// B-spline knot insertion unit
// Holds one planar curve in two memories and refines it by Boehm insertion.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall): one request beat per item. Clear and
//  append beats leave o_stall low unless an append finds its store full; an
//  insert keeps o_stall high until its last output beat is loaded.
//  Output channel (o_valid / i_stall): one beat per refined point, o_last on
//  the final one; an error is a single beat with zero point and o_last set.
//  An insert is sequenced through the single read port of each memory and
//  the bit-serial divider (17 steps per alpha that it divides).
//  The degree register is written from i_cfg_wr_data on i_cfg_wr_en; the user
//  must write it while idle only, which the block itself does not enforce.
//  The output register is loaded while the previous beat is taken, so a
//  stalled receiver just holds the sequencer in its emit or error state.
//  Reset: counts cleared, degree 3, output empty; memories are not cleared
//  and are only read at entries that the counts prove were written.
//  Reads whose data is used never hit an entry written that cycle, so no forwarding.
// ----------------------------------------------------------------------------
module bspline_knot_insertion_unit
    import bki_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int MAX_DEGREE = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_req_type,
    input  logic signed [31:0] i_knot_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic              o_last,
    output logic [1:0]        o_status
);

    localparam int KNOT_CAP = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KAW = $clog2(KNOT_CAP);
    localparam int KCW = $clog2(KNOT_CAP + 1);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);

    // memories: knots, and points packed {x, y}
    logic signed [QW-1:0] r_knot_mem [KNOT_CAP];
    logic [2*QW-1:0]      r_pt_mem   [MAX_POINTS];
    logic signed [QW-1:0] r_knot_rd;
    logic [2*QW-1:0]      r_pt_rd;

    logic           k_we;
    logic [KAW-1:0] k_waddr, k_raddr;
    logic [QW-1:0]  k_wdata;
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [2*QW-1:0] p_wdata;

    t_state r_state, n_state;
    logic [2:0]     r_degree, n_degree;
    logic [KCW-1:0] r_kc, n_kc;
    logic [PCW-1:0] r_pc, n_pc;
    logic signed [QW-1:0] r_u, n_u;
    logic [KCW-1:0] r_p, n_p, r_n, n_n, r_i, n_i, r_k, n_k, r_j, n_j, r_si, n_si;
    logic           r_sv, n_sv, r_lo_err, n_lo_err;
    logic signed [QW-1:0] r_uj, n_uj;
    logic [2*QW-1:0] r_pa, n_pa, r_pb, n_pb;
    logic signed [QW:0] r_dx, n_dx, r_dy, n_dy;
    logic [DVW-1:0] r_rem, n_rem, r_dv, n_dv;
    logic [ALW-1:0] r_q, n_q, r_alpha, n_alpha;
    logic [4:0]     r_db, n_db;
    logic signed [PRW-1:0] r_prod, n_prod;
    logic [QW-1:0]  r_nx, n_nx;
    logic [1:0]     r_code, n_code;
    logic           r_ovld, n_ovld, r_olast, n_olast;
    logic [QW-1:0]  r_ox, n_ox, r_oy, n_oy;
    logic [1:0]     r_ostat, n_ostat;

    // combinational helpers
    logic           accept, out_free, dv_ge;
    logic [KCW-1:0] cur_p, j_lo;
    logic [QW:0]    num33, den33, an, ad;
    logic [DVW-1:0] div_d, div_sat;
    logic [ALW-1:0] q_next;
    logic signed [PRW-1:0] rnd;
    logic [QW-1:0]  f_low;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_ovld || !i_stall;
    assign o_valid  = r_ovld;
    assign o_out_x  = r_ox;
    assign o_out_y  = r_oy;
    assign o_last   = r_olast;
    assign o_status = r_ostat;

    assign cur_p = (int'(r_degree) > MAX_DEGREE) ? KCW'(MAX_DEGREE) : KCW'(r_degree);
    assign j_lo  = r_k + KCW'(1) - r_p;

    // Boehm alpha operands: numerator u - U_j, denominator U_j+p - U_j
    assign num33   = {r_u[QW-1], r_u} - {r_uj[QW-1], r_uj};
    assign den33   = {r_knot_rd[QW-1], r_knot_rd} - {r_uj[QW-1], r_uj};
    assign an      = num33[QW] ? (~num33 + 1'b1) : num33;
    assign ad      = den33[QW] ? (~den33 + 1'b1) : den33;
    assign div_d   = {1'b0, an, 16'b0} + DVW'(ad >> 1);
    assign div_sat = {ad, 17'b0};
    assign dv_ge   = (r_rem >= r_dv);
    assign q_next  = {r_q[ALW-2:0], dv_ge};

    // round half up then floor to Q16.16
    assign rnd   = (r_prod + PRW'(32768)) >>> 16;
    assign f_low = rnd[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            r_knot_mem[k_waddr] <= k_wdata;
        end
        r_knot_rd <= r_knot_mem[k_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pt_mem[p_waddr] <= p_wdata;
        end
        r_pt_rd <= r_pt_mem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd3;
            r_kc     <= '0;
            r_pc     <= '0;
            r_ovld   <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_degree <= n_degree;
            r_kc     <= n_kc;
            r_pc     <= n_pc;
            r_ovld   <= n_ovld;
            r_sv     <= n_sv;
        end
        r_u <= n_u;   r_p <= n_p;   r_n <= n_n;   r_i <= n_i;
        r_k <= n_k;   r_j <= n_j;   r_si <= n_si; r_lo_err <= n_lo_err;
        r_uj <= n_uj; r_pa <= n_pa; r_pb <= n_pb; r_dx <= n_dx; r_dy <= n_dy;
        r_rem <= n_rem; r_dv <= n_dv; r_q <= n_q; r_db <= n_db;
        r_alpha <= n_alpha; r_prod <= n_prod; r_nx <= n_nx; r_code <= n_code;
        r_ox <= n_ox; r_oy <= n_oy; r_olast <= n_olast; r_ostat <= n_ostat;
    end

    always_comb begin
        n_state = r_state;
        n_degree = i_cfg_wr_en ? i_cfg_wr_data : r_degree;
        n_kc = r_kc;   n_pc = r_pc;   n_u = r_u;     n_p = r_p;   n_n = r_n;
        n_i = r_i;     n_k = r_k;     n_j = r_j;     n_si = r_si; n_sv = r_sv;
        n_lo_err = r_lo_err; n_uj = r_uj; n_pa = r_pa; n_pb = r_pb;
        n_dx = r_dx;   n_dy = r_dy;   n_rem = r_rem; n_dv = r_dv; n_q = r_q;
        n_db = r_db;   n_alpha = r_alpha; n_prod = r_prod; n_nx = r_nx;
        n_code = r_code;
        n_ovld = r_ovld && i_stall;
        n_ox = r_ox;   n_oy = r_oy;   n_olast = r_olast; n_ostat = r_ostat;

        k_we = 1'b0; k_waddr = r_i[KAW-1:0]; k_wdata = r_knot_rd; k_raddr = r_i[KAW-1:0];
        p_we = 1'b0; p_waddr = r_i[PAW-1:0]; p_wdata = r_pt_rd;   p_raddr = r_i[PAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_u = i_knot_value;
                    n_p = cur_p;
                    n_n = KCW'(r_pc) - KCW'(1);
                    case (i_req_type)
                        REQ_CLEAR: begin
                            n_kc = '0;
                            n_pc = '0;
                        end
                        REQ_KNOT: begin
                            if (r_kc >= KCW'(KNOT_CAP)) begin
                                n_code  = ST_FULL;
                                n_state = S_ERR;
                            end else begin
                                k_we    = 1'b1;
                                k_waddr = r_kc[KAW-1:0];
                                k_wdata = i_knot_value;
                                n_kc    = r_kc + KCW'(1);
                            end
                        end
                        REQ_POINT: begin
                            if (r_pc >= PCW'(MAX_POINTS)) begin
                                n_code  = ST_FULL;
                                n_state = S_ERR;
                            end else begin
                                p_we    = 1'b1;
                                p_waddr = r_pc[PAW-1:0];
                                p_wdata = {i_point_x, i_point_y};
                                n_pc    = r_pc + PCW'(1);
                            end
                        end
                        default: begin
                            if (r_pc >= PCW'(MAX_POINTS)) begin
                                n_code  = ST_FULL;
                                n_state = S_ERR;
                            end else if (KCW'(r_pc) < cur_p + KCW'(1) ||
                                         r_kc != KCW'(r_pc) + cur_p + KCW'(1)) begin
                                n_code  = ST_RANGE;
                                n_state = S_ERR;
                            end else begin
                                n_state = S_RNG_A;
                            end
                        end
                    endcase
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_ovld = 1'b1; n_ox = '0; n_oy = '0; n_olast = 1'b1;
                    n_ostat = r_code;
                    n_state = S_IDLE;
                end
            end
            // range check against U_p and U_n+1
            S_RNG_A: begin
                k_raddr = r_p[KAW-1:0];
                n_state = S_RNG_B;
            end
            S_RNG_B: begin
                n_lo_err = (r_u < r_knot_rd);
                k_raddr  = KAW'(r_n + KCW'(1));
                n_state  = S_RNG_C;
            end
            S_RNG_C: begin
                if (r_lo_err || r_u > r_knot_rd) begin
                    n_code  = ST_RANGE;
                    n_state = S_ERR;
                end else begin
                    n_i = r_p; n_k = r_p; n_sv = 1'b0;
                    n_state = S_SCAN;
                end
            end
            // span search, one knot a cycle, compared in the cycle after its read
            S_SCAN: begin
                if (r_sv && r_knot_rd <= r_u) begin
                    n_k = r_si;
                end
                if (r_i <= r_n) begin
                    n_si = r_i; n_sv = 1'b1; n_i = r_i + KCW'(1);
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        if (r_p == '0) begin
                            n_i = r_n; n_state = S_SH_RD;
                        end else begin
                            n_j = j_lo; n_state = S_DEN_A;
                        end
                    end
                end
            end
            // all denominators checked before anything is written
            S_DEN_A: begin
                k_raddr = r_j[KAW-1:0];
                n_state = S_DEN_B;
            end
            S_DEN_B: begin
                n_uj    = r_knot_rd;
                k_raddr = KAW'(r_j + r_p);
                n_state = S_DEN_C;
            end
            S_DEN_C: begin
                if (r_knot_rd == r_uj) begin
                    n_code  = ST_ZERO_D;
                    n_state = S_ERR;
                end else if (r_j == r_k) begin
                    n_i = r_n; n_state = S_SH_RD;
                end else begin
                    n_j = r_j + KCW'(1); n_state = S_DEN_A;
                end
            end
            // tail P_k..P_n moves up one place, top first
            S_SH_RD: begin
                p_raddr = r_i[PAW-1:0];
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                p_we    = 1'b1;
                p_waddr = PAW'(r_i + KCW'(1));
                p_wdata = r_pt_rd;
                if (r_i == r_k) begin
                    if (r_p == '0) begin
                        n_i = r_kc; n_state = S_KS_RD;
                    end else begin
                        n_j = r_k; n_state = S_BL_K0;
                    end
                end else begin
                    n_i = r_i - KCW'(1); n_state = S_SH_RD;
                end
            end
            // blends, j descending so P_j-1 and P_j are still the old points
            S_BL_K0: begin
                k_raddr = r_j[KAW-1:0];
                p_raddr = r_j[PAW-1:0];
                n_state = S_BL_K1;
            end
            S_BL_K1: begin
                n_uj    = r_knot_rd;
                n_pb    = r_pt_rd;
                k_raddr = KAW'(r_j + r_p);
                p_raddr = PAW'(r_j - KCW'(1));
                n_state = S_BL_SET;
            end
            S_BL_SET: begin
                n_pa = r_pt_rd;
                n_dx = {r_pb[2*QW-1], r_pb[2*QW-1:QW]} - {r_pt_rd[2*QW-1], r_pt_rd[2*QW-1:QW]};
                n_dy = {r_pb[QW-1], r_pb[QW-1:0]} - {r_pt_rd[QW-1], r_pt_rd[QW-1:0]};
                if ((num33[QW] ^ den33[QW]) != 1'b0) begin
                    n_alpha = '0; n_state = S_BL_MX;
                end else if (div_d >= div_sat) begin
                    n_alpha = ALPHA_ONE; n_state = S_BL_MX;
                end else begin
                    n_rem = div_d;
                    n_dv  = {1'b0, ad, 16'b0};
                    n_q   = '0;
                    n_db  = 5'(ALW - 1);
                    n_state = S_BL_DIV;
                end
            end
            S_BL_DIV: begin
                if (dv_ge) begin
                    n_rem = r_rem - r_dv;
                end
                n_q  = q_next;
                n_dv = r_dv >> 1;
                n_db = r_db - 5'd1;
                if (r_db == '0) begin
                    n_alpha = (q_next > ALPHA_ONE) ? ALPHA_ONE : q_next;
                    n_state = S_BL_MX;
                end
            end
            S_BL_MX: begin
                n_prod  = r_dx * $signed({1'b0, r_alpha});
                n_state = S_BL_MY;
            end
            S_BL_MY: begin
                n_nx    = r_pa[2*QW-1:QW] + f_low;
                n_prod  = r_dy * $signed({1'b0, r_alpha});
                n_state = S_BL_WR;
            end
            S_BL_WR: begin
                p_we    = 1'b1;
                p_waddr = r_j[PAW-1:0];
                p_wdata = {r_nx, r_pa[QW-1:0] + f_low};
                if (r_j == j_lo) begin
                    n_i = r_kc; n_state = S_KS_RD;
                end else begin
                    n_j = r_j - KCW'(1); n_state = S_BL_K0;
                end
            end
            // knots above k move up one place, then u lands at k+1
            S_KS_RD: begin
                if (r_i > r_k + KCW'(1)) begin
                    k_raddr = KAW'(r_i - KCW'(1));
                    n_state = S_KS_WR;
                end else begin
                    k_we    = 1'b1;
                    k_waddr = r_i[KAW-1:0];
                    k_wdata = r_u;
                    n_kc    = r_kc + KCW'(1);
                    n_pc    = r_pc + PCW'(1);
                    n_i     = '0;
                    n_state = S_EM_RD;
                end
            end
            S_KS_WR: begin
                k_we    = 1'b1;
                k_waddr = r_i[KAW-1:0];
                k_wdata = r_knot_rd;
                n_i     = r_i - KCW'(1);
                n_state = S_KS_RD;
            end
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ox    = r_pt_rd[2*QW-1:QW];
                    n_oy    = r_pt_rd[QW-1:0];
                    n_ostat = ST_OK;
                    n_olast = (r_i == KCW'(r_pc) - KCW'(1));
                    if (r_i == KCW'(r_pc) - KCW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + KCW'(1); n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bki_checker.sv =====
// ----------------------------------------------------------------------------
// Knot insertion port checker
// Watches the top-level ports of the knot insertion unit.
// ----------------------------------------------------------------------------
`include "bspline_knot_insertion_unit_defines.svh"

module bki_checker
    import bki_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_wr_en,
    input logic [2:0]        i_cfg_wr_data,
    input logic              i_valid,
    input logic              o_stall,
    input logic [1:0]        i_req_type,
    input logic signed [31:0] i_knot_value,
    input logic signed [31:0] i_point_x,
    input logic signed [31:0] i_point_y,
    input logic              o_valid,
    input logic              i_stall,
    input logic signed [31:0] o_out_x,
    input logic signed [31:0] o_out_y,
    input logic              o_last,
    input logic [1:0]        o_status
);

    // a held beat keeps its payload
    `BKI_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_last) && $stable(o_status), "output beat changed while stalled")

    // error beats are single, zeroed and closing
    `BKI_ASSERT_NOW(a_err_beat, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_last && o_out_x == 0 && o_out_y == 0, "malformed error beat")

    // a point list in flight keeps the input side stalled
    `BKI_ASSERT_NOW(a_list_busy, i_clk, i_rst_n, o_valid && !o_last, o_stall, "input open mid list")

    // an accepted insert always occupies the block
    `BKI_ASSERT_NEXT(a_ins_busy, i_clk, i_rst_n, i_valid && !o_stall && i_req_type == REQ_INSERT, o_stall, "insert not taken up")

endmodule

bind bspline_knot_insertion_unit bki_checker u_bki_checker (.*);

// ===== test/tb_bspline_knot_insertion_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knot insertion unit testbench
// Builds clamped and irregular curves through clear and append beats, then
// refines them by random knot inserts at several degrees. A scoreboard class
// predicts every output beat (refined points and error beats) and compares
// them in order; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bspline_knot_insertion_unit;
    import bki_pkg::*;

    localparam int  NPTS_MAX  = 32;
    localparam int  KNOTS_MAX = 40;
    localparam int  RAND_BEATS = 280;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        t_status            status;
    } t_refined_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the curve, the degree and the pending beats
    // ------------------------------------------------------------------------
    class knot_insertion_scoreboard;
        longint          knots[KNOTS_MAX];
        longint          pts_x[NPTS_MAX];
        longint          pts_y[NPTS_MAX];
        int unsigned     knot_cnt;
        int unsigned     point_cnt;
        int unsigned     degree;
        t_refined_beat   pending[$];
        int              mismatches;

        function new();
            knot_cnt   = 0;
            point_cnt  = 0;
            degree     = 3;
            mismatches = 0;
        endfunction

        function void push_error(t_status code);
            t_refined_beat b;
            b.x = '0;
            b.y = '0;
            b.last = 1'b1;
            b.status = code;
            pending = {pending, b};
        endfunction

        // alpha in Q16.16, rounded half away from zero, held to [0, 1.0]
        function longint alpha_q16(longint num, longint den);
            bit neg;
            longint unsigned an, ad, q;
            neg = (num < 0) != (den < 0);
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            q = ((an << 16) + ad / 2) / ad;
            if (neg || q == 0) return 0;
            return q > 65536 ? 65536 : longint'(q);
        endfunction

        function longint mix(longint a, longint b, longint alpha);
            longint t, f;
            t = (b - a) * alpha + 32768;
            f = t >= 0 ? t / 65536 : -((-t + 65535) / 65536);
            return a + f;
        endfunction

        function void note_request(t_req req, logic [31:0] knot,
                                   logic [31:0] x, logic [31:0] y);
            longint u, den, alpha;
            longint bx[8], by[8], nx[NPTS_MAX], ny[NPTS_MAX];
            int unsigned p, n, k, i, j, m;
            t_refined_beat b;
            u = longint'(signed'(knot));
            p = degree;
            case (req)
                REQ_CLEAR: begin
                    knot_cnt = 0;
                    point_cnt = 0;
                end
                REQ_KNOT: begin
                    if (knot_cnt >= KNOTS_MAX) push_error(ST_FULL);
                    else knots[knot_cnt++] = u;
                end
                REQ_POINT: begin
                    if (point_cnt >= NPTS_MAX) push_error(ST_FULL);
                    else begin
                        pts_x[point_cnt] = longint'(signed'(x));
                        pts_y[point_cnt] = longint'(signed'(y));
                        point_cnt++;
                    end
                end
                default: begin
                    if (point_cnt >= NPTS_MAX) begin
                        push_error(ST_FULL);
                        return;
                    end
                    if (point_cnt < p + 1 || knot_cnt != point_cnt + p + 1) begin
                        push_error(ST_RANGE);
                        return;
                    end
                    n = point_cnt - 1;
                    if (u < knots[p] || u > knots[n + 1]) begin
                        push_error(ST_RANGE);
                        return;
                    end
                    k = p;
                    for (i = p; i <= n; i++)
                        if (knots[i] <= u) k = i;
                    for (j = k + 1 - p; j <= k; j++) begin
                        den = knots[j + p] - knots[j];
                        if (den == 0) begin
                            push_error(ST_ZERO_D);
                            return;
                        end
                        alpha = alpha_q16(u - knots[j], den);
                        bx[j - (k + 1 - p)] = mix(pts_x[j - 1], pts_x[j], alpha);
                        by[j - (k + 1 - p)] = mix(pts_y[j - 1], pts_y[j], alpha);
                    end
                    m = 0;
                    for (i = 0; i + p <= k; i++) begin
                        nx[m] = pts_x[i]; ny[m] = pts_y[i]; m++;
                    end
                    for (i = 0; i < p; i++) begin
                        nx[m] = bx[i]; ny[m] = by[i]; m++;
                    end
                    for (i = k; i <= n; i++) begin
                        nx[m] = pts_x[i]; ny[m] = pts_y[i]; m++;
                    end
                    for (i = knot_cnt; i > k + 1; i--) knots[i] = knots[i - 1];
                    knots[k + 1] = u;
                    knot_cnt++;
                    for (i = 0; i < m; i++) begin
                        pts_x[i] = nx[i];
                        pts_y[i] = ny[i];
                        b.x = nx[i][31:0];
                        b.y = ny[i][31:0];
                        b.last = (i + 1 == m);
                        b.status = ST_OK;
                        pending = {pending, b};
                    end
                    point_cnt = m;
                end
            endcase
        endfunction

        function void check_beat(logic [31:0] x, logic [31:0] y,
                                 logic last, logic [1:0] status);
            t_refined_beat e;
            if (pending.size() == 0) begin
                $error("unexpected output beat x=%h y=%h last=%b status=%0d",
                       x, y, last, status);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) begin
                $error("out_x: expected %h, got %h", e.x, x); mismatches++;
            end
            if (y !== e.y) begin
                $error("out_y: expected %h, got %h", e.y, y); mismatches++;
            end
            if (last !== e.last) begin
                $error("last: expected %b, got %b", e.last, last); mismatches++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, driven inputs known from time zero
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_wr_data = 3'd0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_req_type = REQ_CLEAR;
    logic signed [31:0] i_knot_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_last;
    logic [1:0]         o_status;

    knot_insertion_scoreboard sb;
    bit     tx_quiet = 0;       // sender never idles
    bit     rx_quiet = 0;       // receiver never stalls
    bit     rx_hold_req = 0;    // receiver holds off for a long stretch
    int     sent_beats = 0;
    longint cycles = 0;

    bspline_knot_insertion_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_knot_value  (i_knot_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_last        (o_last),
        .o_status      (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[bspline_knot_insertion_unit] ERROR");
            $finish;
        end
    end

    // output monitor: a beat is taken when valid and not stalled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_beat(o_out_x, o_out_y, o_last, o_status);
    end

    // receiver: random stalls, quiet stretches, and one long hold-off on demand
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (700) @(posedge i_clk);
                rx_hold_req = 0;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 15);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic send_beat(t_req req, logic [31:0] knot, logic [31:0] x,
                             logic [31:0] y);
        if (!tx_quiet && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_type   <= req;
        i_knot_value <= knot;
        i_point_x    <= x;
        i_point_y    <= y;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req, knot, x, y);
        sent_beats++;
    endtask

    task automatic add_knot(longint v);
        send_beat(REQ_KNOT, v[31:0], $urandom, $urandom);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y);
        send_beat(REQ_POINT, $urandom, x, y);
    endtask

    task automatic insert_knot(longint u);
        send_beat(REQ_INSERT, u[31:0], $urandom, $urandom);
    endtask

    // stop offering and wait for every pending beat, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_degree(int unsigned d);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d[2:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.degree = d;
    endtask

    // random curve: non-decreasing knots with occasional repeats and optionally clamped ends
    task automatic build_curve(int unsigned npts);
        int unsigned nk, i, p;
        longint v;
        bit clamp;
        p = sb.degree;
        nk = npts + p + 1;
        clamp = $urandom_range(0, 1);
        v = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
        send_beat(REQ_CLEAR, $urandom, $urandom, $urandom);
        for (i = 0; i < nk; i++) begin
            add_knot(v);
            if (clamp && (i < p || i >= nk - p - 1)) continue;
            if ($urandom_range(0, 9) != 0) v += $urandom_range(1, 1 << 20);
        end
        for (i = 0; i < npts; i++) add_point($urandom, $urandom);
    endtask

    // usually a knot inside the valid range when the curve is well formed, else any value
    task automatic random_insert();
        longint lo, hi, span;
        int unsigned p, n;
        p = sb.degree;
        if (sb.point_cnt >= p + 1 && sb.knot_cnt == sb.point_cnt + p + 1
            && $urandom_range(0, 9) != 0) begin
            n = sb.point_cnt - 1;
            lo = sb.knots[p];
            hi = sb.knots[n + 1];
            span = hi - lo + 1;
            case ($urandom_range(0, 5))
                0: insert_knot(lo);
                1: insert_knot(hi);
                2: insert_knot(sb.knots[$urandom_range(p, n + 1)]);
                default: insert_knot(lo + longint'({$urandom, $urandom} % span));
            endcase
        end else begin
            insert_knot($urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned degs[8];
        int unsigned phase, start, npts, r, i;
        degs = '{5, 0, 7, 2, 1, 4, 6, 3};
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: cubic curve at the extremes of the Q16.16 range
        set_degree(3);
        for (i = 0; i < 4; i++) add_knot(-64'sh8000_0000);
        add_knot(0);
        for (i = 0; i < 4; i++) add_knot(64'sh7FFF_FFFF);
        add_point(32'h8000_0000, 32'h7FFF_FFFF);
        add_point(32'h7FFF_FFFF, 32'h8000_0000);
        add_point(32'h0000_0000, 32'hFFFF_FFFF);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000);
        insert_knot(-64'sh8000_0000);   // lowest knot
        insert_knot(64'sh7FFF_FFFF);    // knot equal to the top of the range
        insert_knot(64'sh0000_8000);
        // knot below the valid range
        build_curve(4);
        insert_knot(sb.knots[3] - 1);
        // malformed curve: too few points after a clear
        send_beat(REQ_CLEAR, '0, '0, '0);
        insert_knot(0);
        // zero denominator: linear curve on a single repeated knot
        set_degree(1);
        for (i = 0; i < 4; i++) add_knot(0);
        add_point(32'h0001_0000, 32'h0002_0000);
        add_point(32'h0003_0000, 32'h0004_0000);
        insert_knot(0);
        // degree zero: the point at the span is duplicated
        set_degree(0);
        build_curve(3);
        random_insert();

        // Random phases, cycling through degrees
        phase = 0;
        start = sent_beats;
        while (sent_beats - start < RAND_BEATS) begin
            set_degree(degs[phase % 8]);
            tx_quiet = (phase == 1);
            rx_quiet = (phase == 1);
            if (phase == 2) rx_hold_req = 1;
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // fill the stores: inserts until full, then overflowing appends
                build_curve(NPTS_MAX - 1);
                random_insert();
                random_insert();
                while (sb.knot_cnt < KNOTS_MAX) add_knot($urandom);
                add_knot($urandom);
                add_point($urandom, $urandom);
                add_point($urandom, $urandom);
            end else begin
                npts = ($urandom_range(0, 7) == 0) ?
                       $urandom_range(sb.degree + 1, 24) :
                       $urandom_range(sb.degree + 1, sb.degree + 5);
                build_curve(npts);
                repeat ($urandom_range(2, 6)) begin
                    if ($urandom_range(0, 4) == 0)
                        send_beat(t_req'($urandom_range(1, 3)), $urandom,
                                  $urandom, $urandom);
                    else
                        random_insert();
                    if ($urandom_range(0, 7) == 0) drain();
                end
            end
            phase++;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[bspline_knot_insertion_unit] OK");
        else
            $display("[bspline_knot_insertion_unit] ERROR");
        $finish;
    end

endmodule
